/* design/spf_pkg.sv */
// Shared types, character codes and byte classifiers for the sender-policy term parser.
package spf_pkg;

   // Character codes
   localparam logic [7:0] CH_PLUS     = 8'h2B;
   localparam logic [7:0] CH_MINUS    = 8'h2D;
   localparam logic [7:0] CH_QUESTION = 8'h3F;
   localparam logic [7:0] CH_TILDE    = 8'h7E;
   localparam logic [7:0] CH_COLON    = 8'h3A;
   localparam logic [7:0] CH_SLASH    = 8'h2F;
   localparam logic [7:0] CH_EQUAL    = 8'h3D;
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_UNDER    = 8'h5F;
   localparam logic [7:0] CH_DOT      = 8'h2E;

   // Result kinds
   localparam logic [1:0] KIND_DIRECTIVE = 2'd0;
   localparam logic [1:0] KIND_MODIFIER  = 2'd1;
   localparam logic [1:0] KIND_ERROR     = 2'd2;

   // Prefix codes
   localparam logic [1:0] PFX_PLUS     = 2'd0;
   localparam logic [1:0] PFX_MINUS    = 2'd1;
   localparam logic [1:0] PFX_QUESTION = 2'd2;
   localparam logic [1:0] PFX_TILDE    = 2'd3;

   // Offsets as they appear on the result channel
   localparam int OUT_OFF_W = 11;

   // Scanner phase, one-hot
   typedef enum logic [6:0] {
      PH_SKIP  = 7'b0000001,
      PH_NAME1 = 7'b0000010,
      PH_NAME  = 7'b0000100,
      PH_VALUE = 7'b0001000,
      PH_SLASH = 7'b0010000,
      PH_DIGIT = 7'b0100000,
      PH_ERR   = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic pfx;
      logic modifier;
      logic val;
      logic cidr;
   } term_flags_type;

   typedef struct packed {
      logic [7:0] char_in;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]           kind;
      logic [1:0]           prefix_code;
      logic [OUT_OFF_W-1:0] name_start;
      logic [OUT_OFF_W-1:0] name_stop;
      logic                 has_value;
      logic [OUT_OFF_W-1:0] value_start;
      logic [OUT_OFF_W-1:0] value_stop;
      logic                 has_cidr;
      logic [OUT_OFF_W-1:0] cidr_start;
      logic [OUT_OFF_W-1:0] cidr_stop;
      logic [OUT_OFF_W-1:0] next_offset;
      logic                 record_done;
   } rsp_type;

   function automatic logic is_alpha(input logic [7:0] c);
      logic [7:0] l;
      l = c | 8'h20;
      return (l >= 8'h61) && (l <= 8'h7A);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_namechar(input logic [7:0] c);
      return is_alpha(c) || is_digit(c) || (c == CH_MINUS) || (c == CH_UNDER)
             || (c == CH_DOT);
   endfunction

   function automatic logic is_prefix(input logic [7:0] c);
      return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_QUESTION) || (c == CH_TILDE);
   endfunction

   function automatic logic [1:0] prefix_of(input logic [7:0] c);
      logic [1:0] code;
      case (c)
         CH_MINUS:    code = PFX_MINUS;
         CH_QUESTION: code = PFX_QUESTION;
         CH_TILDE:    code = PFX_TILDE;
         default:     code = PFX_PLUS;
      endcase
      return code;
   endfunction

   // Error result: everything zero except kind and record_done
   function automatic rsp_type error_rsp();
      rsp_type r;
      r             = '0;
      r.kind        = KIND_ERROR;
      r.record_done = 1'b1;
      return r;
   endfunction

endpackage

/* design/sender_policy_term_parser_unit.sv */
// Sender-policy term parser: byte scanner and result queue.
//
// Usage:
//   req_* carries one record byte per transfer (char_in, last_byte marks the
//   record end). rsp_* delivers one parsed term per transfer: kind, prefix,
//   and the name/value/CIDR offsets within the record, with record_done on
//   the last result of each record. A syntax error gives one error result
//   and the rest of the record is dropped up to its last byte.
//   Throughput: one byte per cycle while req_ready is high; the scanner state
//   updates in the cycle of the byte transfer, so bytes may follow back to back.
//   A term's result is written into the result queue at the edge that takes
//   the byte closing it (the next term's first byte or the last byte) and
//   reaches rsp_* from the following cycle, behind any results still queued.
//   A byte yields at most two results. They go into a four-entry queue;
//   req_ready is high while at least two queue slots are free, so a stalled
//   receiver stops the input after at most four undelivered results.
//   Reset clears the scanner to the start of a record and empties the queue.
//   Offsets beyond RECORD_MAX bytes are not counted; a byte past that limit
//   gives an error.
module sender_policy_term_parser_unit #(
   parameter int RECORD_MAX = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  spf_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output spf_pkg::rsp_type  rsp_data
);
   import spf_pkg::*;

   localparam int OFF_W = $clog2(RECORD_MAX + 1);

   // Scanner state
   phase_type              phase_ff, phase_in;
   logic [OFF_W-1:0]       off_ff, off_in;
   logic [1:0]             prefix_ff, prefix_in;
   logic [OUT_OFF_W-1:0]   name_start_ff, name_start_in;
   logic [OUT_OFF_W-1:0]   name_stop_ff, name_stop_in;
   logic [OUT_OFF_W-1:0]   value_start_ff, value_start_in;
   logic [OUT_OFF_W-1:0]   cidr_start_ff, cidr_start_in;
   logic [OUT_OFF_W-1:0]   term_end_ff, term_end_in;
   term_flags_type         flags_ff, flags_in;
   logic                   pend_ff, pend_in;

   // Result queue
   rsp_type                queue_ff [4];
   logic [1:0]             wr_ptr_ff, wr_ptr_in;
   logic [1:0]             rd_ptr_ff, rd_ptr_in;
   logic [2:0]             cnt_ff, cnt_in;

   logic                   accept;
   logic                   pop;
   rsp_type                res [2];
   logic [1:0]             nres;

   // Builds a term result from the held term fields
   function automatic rsp_type make_term(
      input term_flags_type       fl,
      input logic [1:0]           pfx,
      input logic [OUT_OFF_W-1:0] nstart,
      input logic [OUT_OFF_W-1:0] nstop,
      input logic [OUT_OFF_W-1:0] vstart,
      input logic [OUT_OFF_W-1:0] cstart,
      input logic [OUT_OFF_W-1:0] tend,
      input logic [OUT_OFF_W-1:0] next,
      input logic                 done
   );
      rsp_type r;
      r.kind        = fl.modifier ? KIND_MODIFIER : KIND_DIRECTIVE;
      r.prefix_code = fl.modifier ? PFX_PLUS : pfx;
      r.name_start  = nstart;
      r.name_stop   = nstop;
      r.has_value   = fl.val;
      r.value_start = fl.val ? vstart : '0;
      r.value_stop  = fl.val ? tend : '0;
      r.has_cidr    = fl.cidr;
      r.cidr_start  = fl.cidr ? cstart : '0;
      r.cidr_stop   = fl.cidr ? tend : '0;
      r.next_offset = next;
      r.record_done = done;
      return r;
   endfunction

   assign req_ready = (cnt_ff <= 3'd2);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = (cnt_ff != 3'd0);
   assign rsp_data  = queue_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;

   // Per-byte scan: classify the byte, update term state, form results
   always_comb begin
      logic [7:0]           c;
      logic [OUT_OFF_W-1:0] p11;
      logic [OUT_OFF_W-1:0] rec_end;

      c              = req_data.char_in;
      p11            = OUT_OFF_W'(off_ff);
      phase_in       = phase_ff;
      off_in         = off_ff;
      prefix_in      = prefix_ff;
      name_start_in  = name_start_ff;
      name_stop_in   = name_stop_ff;
      value_start_in = value_start_ff;
      cidr_start_in  = cidr_start_ff;
      term_end_in    = term_end_ff;
      flags_in       = flags_ff;
      pend_in        = pend_ff;
      res[0]         = '0;
      res[1]         = '0;
      nres           = 2'd0;

      if (phase_ff != PH_ERR) begin
         if (off_ff >= OFF_W'(RECORD_MAX)) begin
            // record too long: any held term is dropped
            res[0]   = error_rsp();
            nres     = 2'd1;
            phase_in = PH_ERR;
            pend_in  = 1'b0;
         end else begin
            case (phase_ff)
               PH_SKIP: begin
                  if (c != CH_SPACE) begin
                     // new term starts: flush the held one first
                     if (pend_ff) begin
                        res[0] = make_term(flags_ff, prefix_ff, name_start_ff, name_stop_ff,
                                           value_start_ff, cidr_start_ff, term_end_ff,
                                           p11, 1'b0);
                        nres    = 2'd1;
                        pend_in = 1'b0;
                     end
                     flags_in       = '0;
                     prefix_in      = PFX_PLUS;
                     name_stop_in   = '0;
                     value_start_in = '0;
                     cidr_start_in  = '0;
                     term_end_in    = '0;
                     if (is_prefix(c)) begin
                        prefix_in     = prefix_of(c);
                        flags_in.pfx  = 1'b1;
                        name_start_in = p11 + 11'd1;
                        phase_in      = PH_NAME1;
                     end else if (is_alpha(c)) begin
                        name_start_in = p11;
                        phase_in      = PH_NAME;
                     end else begin
                        res[nres[0]] = error_rsp();
                        nres         = nres + 2'd1;
                        phase_in     = PH_ERR;
                        pend_in      = 1'b0;
                     end
                  end
               end
               PH_NAME1: begin
                  if (is_alpha(c)) begin
                     phase_in = PH_NAME;
                  end else begin
                     res[0]   = error_rsp();
                     nres     = 2'd1;
                     phase_in = PH_ERR;
                     pend_in  = 1'b0;
                  end
               end
               PH_NAME: begin
                  if (!is_namechar(c)) begin
                     name_stop_in = p11;
                     if (c == CH_SPACE) begin
                        term_end_in = p11;
                        pend_in     = 1'b1;
                        phase_in    = PH_SKIP;
                     end else if ((c == CH_COLON) || ((c == CH_EQUAL) && !flags_ff.pfx)) begin
                        flags_in.val      = 1'b1;
                        flags_in.modifier = (c == CH_EQUAL);
                        value_start_in    = p11 + 11'd1;
                        phase_in          = PH_VALUE;
                     end else if (c == CH_SLASH) begin
                        flags_in.cidr = 1'b1;
                        cidr_start_in = p11;
                        phase_in      = PH_SLASH;
                     end else begin
                        res[0]   = error_rsp();
                        nres     = 2'd1;
                        phase_in = PH_ERR;
                        pend_in  = 1'b0;
                     end
                  end
               end
               PH_VALUE: begin
                  if (c == CH_SPACE) begin
                     term_end_in = p11;
                     pend_in     = 1'b1;
                     phase_in    = PH_SKIP;
                  end
               end
               PH_SLASH: begin
                  if (is_digit(c)) begin
                     phase_in = PH_DIGIT;
                  end else begin
                     res[0]   = error_rsp();
                     nres     = 2'd1;
                     phase_in = PH_ERR;
                     pend_in  = 1'b0;
                  end
               end
               PH_DIGIT: begin
                  if (!is_digit(c)) begin
                     if (c == CH_SLASH) begin
                        phase_in = PH_SLASH;
                     end else if (c == CH_SPACE) begin
                        term_end_in = p11;
                        pend_in     = 1'b1;
                        phase_in    = PH_SKIP;
                     end else begin
                        res[0]   = error_rsp();
                        nres     = 2'd1;
                        phase_in = PH_ERR;
                        pend_in  = 1'b0;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
      end

      // offset saturates at the record limit
      if (off_ff < OFF_W'(RECORD_MAX)) begin
         off_in = off_ff + OFF_W'(1);
      end
      rec_end = OUT_OFF_W'(off_in);

      // record end: close whatever is open, then restart
      if (req_data.last_byte) begin
         case (phase_in)
            PH_SKIP: begin
               if (pend_in) begin
                  res[nres[0]] = make_term(flags_in, prefix_in, name_start_in, name_stop_in,
                                           value_start_in, cidr_start_in, term_end_in,
                                           rec_end, 1'b1);
               end else begin
                  res[nres[0]] = error_rsp();
               end
               nres = nres + 2'd1;
            end
            PH_NAME: begin
               res[nres[0]] = make_term(flags_in, prefix_in, name_start_in, rec_end,
                                        value_start_in, cidr_start_in, rec_end,
                                        rec_end, 1'b1);
               nres = nres + 2'd1;
            end
            PH_VALUE, PH_DIGIT: begin
               res[nres[0]] = make_term(flags_in, prefix_in, name_start_in, name_stop_in,
                                        value_start_in, cidr_start_in, rec_end,
                                        rec_end, 1'b1);
               nres = nres + 2'd1;
            end
            PH_NAME1, PH_SLASH: begin
               res[nres[0]] = error_rsp();
               nres = nres + 2'd1;
            end
            default: begin
            end
         endcase
         phase_in       = PH_SKIP;
         off_in         = '0;
         prefix_in      = PFX_PLUS;
         name_start_in  = '0;
         name_stop_in   = '0;
         value_start_in = '0;
         cidr_start_in  = '0;
         term_end_in    = '0;
         flags_in       = '0;
         pend_in        = 1'b0;
      end
   end

   // Queue pointers and fill count
   always_comb begin
      logic [1:0] push;
      push      = accept ? nres : 2'd0;
      wr_ptr_in = wr_ptr_ff + push;
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      cnt_in    = cnt_ff + {1'b0, push} - {2'b00, pop};
   end

   // Control and scanner state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_SKIP;
         off_ff         <= '0;
         prefix_ff      <= PFX_PLUS;
         name_start_ff  <= '0;
         name_stop_ff   <= '0;
         value_start_ff <= '0;
         cidr_start_ff  <= '0;
         term_end_ff    <= '0;
         flags_ff       <= '0;
         pend_ff        <= 1'b0;
         wr_ptr_ff      <= '0;
         rd_ptr_ff      <= '0;
         cnt_ff         <= '0;
      end else begin
         if (accept) begin
            phase_ff       <= phase_in;
            off_ff         <= off_in;
            prefix_ff      <= prefix_in;
            name_start_ff  <= name_start_in;
            name_stop_ff   <= name_stop_in;
            value_start_ff <= value_start_in;
            cidr_start_ff  <= cidr_start_in;
            term_end_ff    <= term_end_in;
            flags_ff       <= flags_in;
            pend_ff        <= pend_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Queue payload, no reset
   always_ff @(posedge clock) begin
      if (accept && (nres != 2'd0)) begin
         queue_ff[wr_ptr_ff] <= res[0];
      end
      if (accept && (nres == 2'd2)) begin
         queue_ff[wr_ptr_ff + 2'd1] <= res[1];
      end
   end

   // Checks
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'd4)
      else $error("result queue overflow");

   a_offset_bound: assert property (@(posedge clock) disable iff (reset)
      off_ff <= OFF_W'(RECORD_MAX))
      else $error("byte offset past record limit");

   a_error_ends_record: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind == KIND_ERROR) |-> rsp_data.record_done)
      else $error("error result without record_done");

   a_restart_after_last: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.last_byte |=> (phase_ff == PH_SKIP) && (off_ff == '0) && !pend_ff)
      else $error("scanner not restarted after record end");

endmodule

/* sim/spf_term_checker.sv */
// Checker for the sender-policy term parser: tracks byte transfers, predicts terms, compares.
`timescale 1ns / 100ps

module spf_term_checker #(
   parameter int RECORD_MAX = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  spf_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  spf_pkg::rsp_type rsp_data,
   output int               mismatch_count,
   output int               terms_outstanding
);
   import spf_pkg::*;

   // Scanner copy
   phase_type      scan_phase;
   logic [10:0]    next_pos;
   logic [1:0]     tprefix;
   logic [10:0]    name_lo;
   logic [10:0]    name_hi;
   logic [10:0]    value_lo;
   logic [10:0]    slash_lo;
   logic [10:0]    term_stop;
   term_flags_type tflags;
   logic           held_term;

   rsp_type expected_terms[$];
   int      fail_total = 0;

   // Byte classes
   function automatic logic letter_byte(input logic [7:0] c);
      logic [7:0] low;
      low = c | 8'h20;
      return (low >= "a") && (low <= "z");
   endfunction

   function automatic logic digit_byte(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic name_byte(input logic [7:0] c);
      return letter_byte(c) || digit_byte(c) || (c == CH_MINUS) || (c == CH_UNDER)
             || (c == CH_DOT);
   endfunction

   task automatic clear_scanner();
      scan_phase = PH_SKIP;
      next_pos   = '0;
      tprefix    = PFX_PLUS;
      name_lo    = '0;
      name_hi    = '0;
      value_lo   = '0;
      slash_lo   = '0;
      term_stop  = '0;
      tflags     = '0;
      held_term  = 1'b0;
   endtask

   task automatic push_term(input logic [10:0] next, input logic done);
      rsp_type r;
      r             = '0;
      r.kind        = tflags.modifier ? KIND_MODIFIER : KIND_DIRECTIVE;
      r.prefix_code = tflags.modifier ? PFX_PLUS : tprefix;
      r.name_start  = name_lo;
      r.name_stop   = name_hi;
      if (tflags.val) begin
         r.has_value   = 1'b1;
         r.value_start = value_lo;
         r.value_stop  = term_stop;
      end
      if (tflags.cidr) begin
         r.has_cidr   = 1'b1;
         r.cidr_start = slash_lo;
         r.cidr_stop  = term_stop;
      end
      r.next_offset = next;
      r.record_done = done;
      expected_terms.push_back(r);
   endtask

   // Error ends the record: later bytes are dropped, any held term too
   task automatic push_error();
      rsp_type r;
      r             = '0;
      r.kind        = KIND_ERROR;
      r.record_done = 1'b1;
      expected_terms.push_back(r);
      scan_phase = PH_ERR;
      held_term  = 1'b0;
   endtask

   task automatic close_term(input logic [10:0] pos);
      term_stop  = pos;
      held_term  = 1'b1;
      scan_phase = PH_SKIP;
   endtask

   // One accepted byte: advance the scanner and queue the terms it finishes
   task automatic parse_record_byte(input logic [7:0] c, input logic is_last);
      logic [10:0] pos;
      pos = next_pos;
      if (scan_phase != PH_ERR) begin
         if (pos >= RECORD_MAX) begin
            push_error();
         end else begin
            case (scan_phase)
               PH_SKIP: begin
                  if (c != CH_SPACE) begin
                     // a new term releases the held one
                     if (held_term) begin
                        push_term(pos, 1'b0);
                        held_term = 1'b0;
                     end
                     tflags    = '0;
                     tprefix   = PFX_PLUS;
                     name_hi   = '0;
                     value_lo  = '0;
                     slash_lo  = '0;
                     term_stop = '0;
                     if ((c == CH_PLUS) || (c == CH_MINUS) || (c == CH_QUESTION)
                         || (c == CH_TILDE)) begin
                        case (c)
                           CH_MINUS:    tprefix = PFX_MINUS;
                           CH_QUESTION: tprefix = PFX_QUESTION;
                           CH_TILDE:    tprefix = PFX_TILDE;
                           default:     tprefix = PFX_PLUS;
                        endcase
                        tflags.pfx = 1'b1;
                        name_lo    = pos + 11'd1;
                        scan_phase = PH_NAME1;
                     end else if (letter_byte(c)) begin
                        name_lo    = pos;
                        scan_phase = PH_NAME;
                     end else begin
                        push_error();
                     end
                  end
               end
               PH_NAME1: begin
                  if (letter_byte(c)) scan_phase = PH_NAME;
                  else push_error();
               end
               PH_NAME: begin
                  if (!name_byte(c)) begin
                     name_hi = pos;
                     if (c == CH_SPACE) begin
                        close_term(pos);
                     end else if ((c == CH_COLON) || ((c == CH_EQUAL) && !tflags.pfx)) begin
                        // modifiers only without an explicit prefix
                        tflags.val      = 1'b1;
                        tflags.modifier = (c == CH_EQUAL);
                        value_lo        = pos + 11'd1;
                        scan_phase      = PH_VALUE;
                     end else if (c == CH_SLASH) begin
                        tflags.cidr = 1'b1;
                        slash_lo    = pos;
                        scan_phase  = PH_SLASH;
                     end else begin
                        push_error();
                     end
                  end
               end
               PH_VALUE: begin
                  if (c == CH_SPACE) close_term(pos);
               end
               PH_SLASH: begin
                  if (digit_byte(c)) scan_phase = PH_DIGIT;
                  else push_error();
               end
               PH_DIGIT: begin
                  if (!digit_byte(c)) begin
                     if (c == CH_SLASH) scan_phase = PH_SLASH;
                     else if (c == CH_SPACE) close_term(pos);
                     else push_error();
                  end
               end
               default: ;
            endcase
         end
      end
      // offset saturates at the record limit
      if (next_pos < RECORD_MAX) next_pos = next_pos + 11'd1;

      // record end: flush the open or held term
      if (is_last) begin
         case (scan_phase)
            PH_SKIP: begin
               if (held_term) push_term(next_pos, 1'b1);
               else push_error();
            end
            PH_NAME: begin
               name_hi   = next_pos;
               term_stop = next_pos;
               push_term(next_pos, 1'b1);
            end
            PH_VALUE, PH_DIGIT: begin
               term_stop = next_pos;
               push_term(next_pos, 1'b1);
            end
            PH_NAME1, PH_SLASH: push_error();
            default: ;
         endcase
         clear_scanner();
      end
   endtask

   task automatic report_mismatch(input string msg);
      $display("ERROR %0t: %s", $time, msg);
      fail_total++;
   endtask

   task automatic check_field(input string field, input logic [10:0] got,
                              input logic [10:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0d expected %0d", field, got, want));
   endtask

   task automatic compare_result(input rsp_type got);
      rsp_type want;
      if (expected_terms.size() == 0) begin
         report_mismatch("result transfer with no term expected");
      end else begin
         want = expected_terms.pop_front();
         check_field("kind", 11'(got.kind), 11'(want.kind));
         check_field("prefix_code", 11'(got.prefix_code), 11'(want.prefix_code));
         check_field("name_start", got.name_start, want.name_start);
         check_field("name_stop", got.name_stop, want.name_stop);
         check_field("has_value", 11'(got.has_value), 11'(want.has_value));
         check_field("value_start", got.value_start, want.value_start);
         check_field("value_stop", got.value_stop, want.value_stop);
         check_field("has_cidr", 11'(got.has_cidr), 11'(want.has_cidr));
         check_field("cidr_start", got.cidr_start, want.cidr_start);
         check_field("cidr_stop", got.cidr_stop, want.cidr_stop);
         check_field("next_offset", got.next_offset, want.next_offset);
         check_field("record_done", 11'(got.record_done), 11'(want.record_done));
      end
   endtask

   initial clear_scanner();

   // Results out of this edge came from earlier bytes, so compare first
   always @(posedge clock) begin
      if (reset) begin
         clear_scanner();
         expected_terms.delete();
      end else begin
         if (rsp_valid && rsp_ready) compare_result(rsp_data);
         if (req_valid && req_ready) parse_record_byte(req_data.char_in, req_data.last_byte);
      end
      terms_outstanding <= expected_terms.size();
      mismatch_count    <= fail_total;
   end

endmodule

/* sim/sender_policy_term_parser_unit_tb.sv */
// Testbench top for the sender-policy term parser: record stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module sender_policy_term_parser_unit_tb;
   import spf_pkg::*;

   localparam int RECORD_LIMIT   = 1024;
   localparam int WATCHDOG_LIMIT = 4000;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int mismatch_count;
   int terms_outstanding;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int bytes_sent    = 0;
   int quiet_cycles  = 0;

   logic [7:0] record_text[$];

   sender_policy_term_parser_unit #(
      .RECORD_MAX (RECORD_LIMIT)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   spf_term_checker #(
      .RECORD_MAX (RECORD_LIMIT)
   ) u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data          (req_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_data          (rsp_data),
      .mismatch_count    (mismatch_count),
      .terms_outstanding (terms_outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Receiver backpressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Watchdog: too long without any transfer ends the run
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("sender_policy_term_parser_unit_tb failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // One byte transfer, with random idle cycles ahead of it
   task automatic send_byte(input logic [7:0] value, input logic is_last);
      req_type item;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      item.char_in   = value;
      item.last_byte = is_last;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
   endtask

   task automatic send_record();
      int n;
      n = record_text.size();
      for (int i = 0; i < n; i++) send_byte(record_text[i], i == n - 1);
   endtask

   // Hold off input until every predicted term has come back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (terms_outstanding != 0);
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) record_text.push_back(s[i]);
   endtask

   task automatic send_text(input string s);
      record_text.delete();
      push_text(s);
      send_record();
   endtask

   task automatic append_name();
      int n;
      record_text.push_back(8'(($urandom_range(1) ? "A" : "a") + $urandom_range(25)));
      n = $urandom_range(6);
      repeat (n) begin
         case ($urandom_range(4))
            0: record_text.push_back(8'("a" + $urandom_range(25)));
            1: record_text.push_back(8'("A" + $urandom_range(25)));
            2: record_text.push_back(8'("0" + $urandom_range(9)));
            3: record_text.push_back($urandom_range(1) ? CH_MINUS : CH_UNDER);
            default: record_text.push_back(CH_DOT);
         endcase
      end
   endtask

   // Value bytes: anything but a space, odd bytes included
   task automatic append_value();
      logic [7:0] b;
      repeat ($urandom_range(6)) begin
         b = 8'($urandom_range(255));
         if (b == CH_SPACE) b = 8'hA0;
         record_text.push_back(b);
      end
   endtask

   // kinds: 0 bare directive, 1 directive with value, 2 directive with CIDR, 3 modifier
   task automatic append_term();
      int kind_sel;
      kind_sel = $urandom_range(3);
      if (kind_sel != 3 && $urandom_range(1)) begin
         case ($urandom_range(3))
            0: record_text.push_back(CH_PLUS);
            1: record_text.push_back(CH_MINUS);
            2: record_text.push_back(CH_QUESTION);
            default: record_text.push_back(CH_TILDE);
         endcase
      end
      append_name();
      case (kind_sel)
         1: begin
            record_text.push_back(CH_COLON);
            append_value();
         end
         2: begin
            repeat ($urandom_range(1, 3)) begin
               record_text.push_back(CH_SLASH);
               repeat ($urandom_range(1, 3))
                  record_text.push_back(8'("0" + $urandom_range(9)));
            end
         end
         3: begin
            record_text.push_back(CH_EQUAL);
            append_value();
         end
         default: ;
      endcase
   endtask

   // Mostly well-formed records; the rest corrupted, cut short, noise or blank
   task automatic build_record();
      int n_terms;
      int sel;
      int cut;
      record_text.delete();
      if ($urandom_range(3) == 0) record_text.push_back(CH_SPACE);
      n_terms = $urandom_range(1, 4);
      for (int i = 0; i < n_terms; i++) begin
         append_term();
         if (i < n_terms - 1) repeat ($urandom_range(1, 2)) record_text.push_back(CH_SPACE);
      end
      if ($urandom_range(3) == 0) record_text.push_back(CH_SPACE);
      sel = $urandom_range(99);
      if (sel < 8) begin
         repeat ($urandom_range(1, 2))
            record_text[$urandom_range(record_text.size() - 1)] = 8'($urandom_range(255));
      end else if (sel < 16) begin
         cut = $urandom_range(1, record_text.size());
         while (record_text.size() > cut) void'(record_text.pop_back());
      end else if (sel < 20) begin
         record_text.delete();
         repeat ($urandom_range(1, 8)) record_text.push_back(8'($urandom_range(255)));
      end else if (sel < 23) begin
         record_text.delete();
         repeat ($urandom_range(1, 3)) record_text.push_back(CH_SPACE);
      end
   endtask

   task automatic run_random(input int budget);
      int start_count;
      start_count = bytes_sent;
      while (bytes_sent - start_count < budget) begin
         build_record();
         send_record();
         if ($urandom_range(19) == 0) wait_for_results();
      end
      wait_for_results();
   endtask

   initial begin
      int target;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Phase one: sender idles a little, receiver a lot
      send_idle_pct = 21;
      recv_idle_pct = 68;

      // Directed: single-byte term, blank record, bare prefix, dangling slash
      send_text("a");
      send_text(" ");
      send_text("+");
      send_text("a/");
      // modifier, the ?, ~ and - prefixes, CIDR, value, extreme byte values
      record_text.delete();
      push_text("m=");
      record_text.push_back(8'h00);
      push_text(" ?b/9 ~c:");
      record_text.push_back(8'hFF);
      push_text(" -d");
      send_record();
      // record opening with a non-letter byte
      record_text.delete();
      record_text.push_back(8'hFF);
      send_record();
      // prefixed modifier is a syntax error
      send_text("-q=1");
      wait_for_results();

      run_random(170);

      // Phase two: the other way round
      send_idle_pct = 68;
      recv_idle_pct = 21;
      run_random(170);

      // Phase three: no idling; one record running up to or past the length limit
      send_idle_pct = 0;
      recv_idle_pct = 0;
      target = RECORD_LIMIT + $urandom_range(3);
      record_text.delete();
      while (record_text.size() < target) begin
         append_term();
         record_text.push_back(CH_SPACE);
      end
      while (record_text.size() > target) void'(record_text.pop_back());
      send_record();
      wait_for_results();
      run_random(170);

      // Let any late transfer show up before the verdict
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && terms_outstanding == 0) begin
         $display("sender_policy_term_parser_unit_tb passed");
      end else begin
         $display("sender_policy_term_parser_unit_tb failed");
      end
      $finish;
   end

endmodule
